// ===== src/lacf_pkg.sv =====
// shared types, constants and byte functions of the lamp advert command framer
package lacf_pkg;

	localparam int LACF_QUEUE_DEPTH = 2;

	localparam int CMD_W = 3;
	localparam logic [CMD_W-1:0] CMD_ON     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_OFF    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LEVEL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TEMP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESYNC = 3'd4;

	localparam logic [1:0] ST_FRAME    = 2'd0;
	localparam logic [1:0] ST_DROPPED  = 2'd1;
	localparam logic [1:0] ST_SYNC_OK  = 2'd2;
	localparam logic [1:0] ST_SYNC_BAD = 2'd3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PINNED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PREFIX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLAGS  = 2'd2;

	localparam logic [4:0] IDX_PREFIX   = 5'd7;
	localparam logic [4:0] IDX_PRE_END  = 5'd14;
	localparam logic [4:0] IDX_BODY     = 5'd15;
	localparam logic [4:0] IDX_BODY_END = 5'd25;
	localparam logic [4:0] IDX_TAIL0    = 5'd26;
	localparam logic [4:0] IDX_TAIL1    = 5'd27;
	localparam logic [4:0] IDX_CRC_LO   = 5'd28;
	localparam logic [4:0] IDX_CRC_HI   = 5'd29;
	localparam logic [4:0] IDX_END      = 5'd30;

	localparam logic [15:0] CRC_POLY  = 16'h8408;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_XOR   = 16'hFFFF ^ 16'h6A4D;
	localparam logic [7:0]  TAIL0_XOR = 8'hB6;
	localparam logic [7:0]  TAIL1_XOR = 8'h2E;

	typedef struct packed {
		logic        is_frame;
		logic [1:0]  status;
		logic [1:0]  kind;
		logic [7:0]  b6;
		logic [7:0]  b7;
		logic [7:0]  seq;
		logic [63:0] prefix;
	} job_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] mask_byte(input logic [3:0] i);
		logic [7:0] m;
		case (i)
			4'd0: m = 8'hE5;
			4'd1: m = 8'h1D;
			4'd2: m = 8'hFE;
			4'd3: m = 8'hB8;
			4'd4: m = 8'h51;
			4'd5: m = 8'hFA;
			4'd6: m = 8'h2A;
			4'd7: m = 8'hB4;
			4'd8: m = 8'hE7;
			4'd9: m = 8'hD4;
			4'd10: m = 8'h0C;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	// unmasked payload byte; kind is the low bits of the command
	function automatic logic [7:0] payload_byte(input logic [1:0] kind, input logic [7:0] b6,
		input logic [7:0] b7, input logic [3:0] i);
		logic       rich;
		logic [7:0] p;
		rich = (kind == CMD_LEVEL[1:0]) || (kind == CMD_TEMP[1:0]);
		case (i)
			4'd0: p = rich ? 8'h83 : 8'h86;
			4'd1: p = 8'h31;
			4'd2: p = 8'h17;
			4'd3: p = 8'h01;
			4'd4: p = rich ? ((kind == CMD_TEMP[1:0]) ? 8'h07 : 8'h05) : 8'h00;
			4'd5: p = rich ? 8'h65 : 8'h01;
			4'd6: p = b6;
			4'd7: p = b7;
			4'd8: p = rich ? 8'h9A : 8'hFE;
			4'd9: p = 8'h55;
			4'd10: p = 8'h55;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

endpackage

// ===== src/lacf_front.sv =====
// front: accepts commands, keeps pairing and sequence state, builds jobs
module lacf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          command,
	input  logic [7:0]          level,
	input  logic [7:0]          cold,
	input  logic [7:0]          warm,
	input  logic [63:0]         sync_prefix,
	input  logic [7:0]          sync_sequence,
	input  logic                prefix_pinned,
	input  logic [63:0]         pinned_prefix,
	input  logic                q_full,
	output logic                push,
	output lacf_pkg::job_t      push_job
);
	import lacf_pkg::*;

	logic [7:0]  sequence_q;
	logic [63:0] learned_prefix_q;
	logic        paired_q;
	logic        accept;
	logic        sync_ok;
	logic        unpaired;
	logic [7:0]  lvl;
	logic [7:0]  cold_c;
	logic [7:0]  warm_c;

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;
	assign unpaired = ~prefix_pinned & ~paired_q;
	assign sync_ok  = ~prefix_pinned | (sync_prefix == pinned_prefix);

	always_comb begin
		if (level == 8'd0) begin
			lvl = 8'd1;
		end else if (level > 8'd100) begin
			lvl = 8'd100;
		end else begin
			lvl = level;
		end
		cold_c = (cold > 8'd100) ? 8'd100 : cold;
		warm_c = (warm > 8'd100) ? 8'd100 : warm;
	end

	always_comb begin
		push              = accept;
		push_job.is_frame = 1'b0;
		push_job.status   = ST_FRAME;
		push_job.kind     = command[1:0];
		push_job.b6       = 8'h01;
		push_job.b7       = 8'hFF;
		push_job.seq      = sequence_q;
		push_job.prefix   = prefix_pinned ? pinned_prefix : learned_prefix_q;
		case (command)
			CMD_RESYNC: begin
				push_job.status = sync_ok ? ST_SYNC_OK : ST_SYNC_BAD;
			end
			CMD_ON, CMD_OFF, CMD_LEVEL, CMD_TEMP: begin
				if (unpaired) begin
					push_job.status = ST_DROPPED;
				end else begin
					push_job.is_frame = 1'b1;
				end
				case (command)
					CMD_OFF: begin
						push_job.b6 = 8'h02;
					end
					CMD_LEVEL: begin
						push_job.b6 = lvl;
						push_job.b7 = 8'hFA;
					end
					CMD_TEMP: begin
						push_job.b6 = cold_c;
						push_job.b7 = warm_c;
					end
					default: begin
						push_job.b6 = 8'h01;
					end
				endcase
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sequence_q       <= 8'd0;
			learned_prefix_q <= 64'd0;
			paired_q         <= 1'b0;
		end else if (accept) begin
			if (command == CMD_RESYNC) begin
				if (sync_ok) begin
					sequence_q <= sync_sequence;
				end
				if (!prefix_pinned) begin
					learned_prefix_q <= sync_prefix;
					paired_q         <= 1'b1;
				end
			end else if (command < CMD_RESYNC && !unpaired) begin
				sequence_q <= sequence_q + 8'd1;
			end
		end
	end

endmodule

// ===== src/lacf_queue.sv =====
// short job queue between front and back
module lacf_queue #(
	parameter int DEPTH = lacf_pkg::LACF_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lacf_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output lacf_pkg::job_t head_job
);
	import lacf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/lacf_back.sv =====
// back: serializes one job into frame bytes with running checksum and crc
module lacf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  lacf_pkg::job_t head_job,
	output logic           pop,
	input  logic [7:0]     flags_byte,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     frame_byte,
	output logic           last,
	output logic [1:0]     status
);
	import lacf_pkg::*;

	job_t        job_q;
	logic        valid_q;
	logic [4:0]  idx_q;
	logic [15:0] crc_q;
	logic [7:0]  sum_q;
	logic [7:0]  byte_c;
	logic [7:0]  pay_c;
	logic [4:0]  pre_off;
	logic [4:0]  body_off;
	logic [63:0] pre_sh;
	logic [15:0] crc_out;
	logic        out_xfer;
	logic        load;
	logic        in_crc;
	logic        in_body;

	assign pre_off  = idx_q - IDX_PREFIX;
	assign body_off = idx_q - IDX_BODY;
	assign pre_sh   = job_q.prefix << {pre_off[2:0], 3'b000};
	assign pay_c    = payload_byte(job_q.kind, job_q.b6, job_q.b7, body_off[3:0]);
	assign crc_out  = crc_q ^ CRC_XOR;
	assign in_crc   = (idx_q >= IDX_PREFIX) && (idx_q <= IDX_TAIL1);
	assign in_body  = (idx_q >= IDX_BODY) && (idx_q <= IDX_BODY_END);

	always_comb begin
		if (idx_q >= IDX_PREFIX && idx_q <= IDX_PRE_END) begin
			byte_c = pre_sh[63:56];
		end else if (in_body) begin
			byte_c = pay_c ^ mask_byte(body_off[3:0]);
		end else begin
			case (idx_q)
				5'd0: byte_c = 8'h02;
				5'd1: byte_c = 8'h01;
				5'd2: byte_c = flags_byte;
				5'd3: byte_c = 8'h1B;
				5'd4: byte_c = 8'hFF;
				5'd5: byte_c = 8'hF0;
				5'd6: byte_c = 8'hFF;
				IDX_TAIL0: byte_c = job_q.seq ^ TAIL0_XOR;
				IDX_TAIL1: byte_c = sum_q ^ TAIL1_XOR;
				IDX_CRC_LO: byte_c = crc_out[7:0];
				IDX_CRC_HI: byte_c = crc_out[15:8];
				IDX_END: byte_c = 8'h18;
				default: byte_c = 8'h00;
			endcase
		end
	end

	assign out_valid  = valid_q;
	assign frame_byte = job_q.is_frame ? byte_c : 8'h00;
	assign last       = job_q.is_frame ? (idx_q == IDX_END) : 1'b1;
	assign status     = job_q.status;

	assign out_xfer = valid_q & ~out_stall;
	assign load     = ~valid_q | (out_xfer & last);
	assign pop      = load & head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 5'd0;
		end else if (load) begin
			valid_q <= head_valid;
			idx_q   <= 5'd0;
		end else if (out_xfer) begin
			idx_q <= idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= head_job;
			crc_q <= CRC_INIT;
			sum_q <= head_job.seq;
		end else if (out_xfer) begin
			if (in_crc) begin
				crc_q <= crc_byte(crc_q, byte_c);
			end
			if (in_body) begin
				sum_q <= sum_q + pay_c;
			end
		end
	end

endmodule

// ===== src/lamp_advert_command_framer_unit.sv =====
// top level of the lamp advert command framer: config registers, front, queue, back
//
// channel  direction  handshake              payload
// in       in         in_valid / in_stall    command level cold warm sync_prefix sync_sequence
// out      out        out_valid / out_stall  frame_byte last status
// cfg      in         cfg_valid / cfg_ready  cfg_index cfg_data
//
// a frame command leaves as 31 bytes, one per cycle while out_stall is low, from the byte serializer in the back;
// status results leave as a single byte; a queued next job starts in the cycle after the last byte
// the front takes a command each cycle while the job queue has room
// reset is asynchronous and needs no clearing pass; state is usable on the first clock
// out_stall holds the current byte and freezes the serializer; in_stall means the queue is full
module lamp_advert_command_framer_unit #(
	parameter int QUEUE_DEPTH = lacf_pkg::LACF_QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         command,
	input  logic [7:0]                         level,
	input  logic [7:0]                         cold,
	input  logic [7:0]                         warm,
	input  logic [63:0]                        sync_prefix,
	input  logic [7:0]                         sync_sequence,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         frame_byte,
	output logic                               last,
	output logic [1:0]                         status,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lacf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                        cfg_data
);
	import lacf_pkg::*;

	logic        prefix_pinned_q;
	logic [63:0] pinned_prefix_q;
	logic [7:0]  flags_byte_q;
	logic        push;
	job_t        push_job;
	logic        q_full;
	logic        pop;
	logic        head_valid;
	job_t        head_job;
	logic        cfg_xfer;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_pinned_q <= 1'b0;
			pinned_prefix_q <= 64'd0;
			flags_byte_q    <= 8'd0;
		end else if (cfg_xfer) begin
			case (cfg_index)
				CFG_PINNED: prefix_pinned_q <= cfg_data[0];
				CFG_PREFIX: pinned_prefix_q <= cfg_data;
				CFG_FLAGS:  flags_byte_q    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	lacf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.level         (level),
		.cold          (cold),
		.warm          (warm),
		.sync_prefix   (sync_prefix),
		.sync_sequence (sync_sequence),
		.prefix_pinned (prefix_pinned_q),
		.pinned_prefix (pinned_prefix_q),
		.q_full        (q_full),
		.push          (push),
		.push_job      (push_job)
	);

	lacf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	lacf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.flags_byte (flags_byte_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last       (last),
		.status     (status)
	);

endmodule
